/* rtl/wth_pkg.sv */
// ----------------------------------------------------------------------------
// wth_pkg: shared types and constants for the word tokenizer / hash block
// Byte codes, the queue entry handed from front to back, and the hash step.
// ----------------------------------------------------------------------------
package wth_pkg;

  localparam int          MaxLenDef     = 1024;
  localparam int          BucketBitsDef = 20;
  localparam logic [31:0] SeedReset     = 32'd1159241;
  localparam logic [31:0] Mask31        = 32'h7fff_ffff;

  localparam int BucketW = 20;
  localparam int TokLenW = 10;

  // entries in the front/back queue, power of two
  localparam int QueueDepth = 4;

  // control and white-space characters
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChVt    = 8'h0B;
  localparam logic [7:0] ChFf    = 8'h0C;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;

  // one queue entry: an optional closed token, then an optional punctuation token
  typedef struct packed {
    logic               has_tok;
    logic [BucketW-1:0] tok_bucket;
    logic [TokLenW-1:0] tok_len;
    logic               has_punct;
    logic [BucketW-1:0] punct_bucket;
  } wth_entry_t;

  function automatic logic is_delim(input logic [7:0] b);
    return (b == ChSpace) || (b == ChTab) || (b == ChLf) || (b == ChNul) ||
           (b == ChVt) || (b == ChFf);
  endfunction

  function automatic logic is_punct(input logic [7:0] b);
    return (b >= 8'h21 && b <= 8'h2F) || (b >= 8'h3A && b <= 8'h40) ||
           (b >= 8'h5B && b <= 8'h60) || (b >= 8'h7B && b <= 8'h7E);
  endfunction

  // shift-add-xor step over the sign-extended byte
  function automatic logic [31:0] mix_byte(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] c;
    c = {{24{b[7]}}, b};
    return h ^ ((h << 5) + c + (h >> 2));
  endfunction

endpackage

/* rtl/word_tokenizer_hash_top.sv */
// A token's result is registered into the queue by the request that closes it and shows on the out_ ports at the head.
// Throughput: one byte request per cycle while the queue is not full; the running hash step is one add/xor per cycle.
// A punctuation byte that closes a token yields two results, popped one at a time;
// a 4-entry queue between front and back absorbs that and out-side stalls.
// Reset (rst_n low, synchronous): seed back to 1159241, no open token, queue empty.
// ----------------------------------------------------------------------------
// word_tokenizer_hash_top: streaming word tokenizer with shift-add-xor hash
// Front classifies bytes and keeps the token hash; back delivers results.
// ----------------------------------------------------------------------------
module word_tokenizer_hash_top
  import wth_pkg::*;
#(
  parameter int MAX_LEN     = MaxLenDef,
  parameter int BUCKET_BITS = BucketBitsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  // seed register
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data,
  // byte requests
  input  logic               push,
  output logic               full,
  input  logic [7:0]         in_byte,
  input  logic               in_end_mark,
  // results
  output logic               empty,
  input  logic               pop,
  output logic [BucketW-1:0] out_bucket,
  output logic [TokLenW-1:0] out_token_length,
  output logic               out_last_result
);

  logic       accept;
  logic       q_wr_en;
  wth_entry_t q_wr_data;
  logic       q_rd_en;
  wth_entry_t q_head;
  logic       q_empty;

  // a request is taken whenever the queue has room; it never waits on the back
  assign accept = push && !full;

  wth_front #(
    .MAX_LEN     (MAX_LEN),
    .BUCKET_BITS (BUCKET_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .in_byte     (in_byte),
    .in_end_mark (in_end_mark),
    .wr_en       (q_wr_en),
    .wr_data     (q_wr_data)
  );

  // entries carry a finished token and/or a punctuation token
  wth_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr_en),
    .wr_data (q_wr_data),
    .rd_en   (q_rd_en),
    .rd_data (q_head),
    .full    (full),
    .empty   (q_empty)
  );

  wth_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (q_head),
    .q_empty          (q_empty),
    .q_rd_en          (q_rd_en),
    .pop              (pop),
    .empty            (empty),
    .out_bucket       (out_bucket),
    .out_token_length (out_token_length),
    .out_last_result  (out_last_result)
  );

endmodule

/* rtl/wth_front.sv */
// ----------------------------------------------------------------------------
// wth_front: byte classifier and running hash
// Holds the open token's hash, length and last three bytes; writes one queue
// entry for each request that finishes a token or forms a punctuation token.
// ----------------------------------------------------------------------------
module wth_front
  import wth_pkg::*;
#(
  parameter int MAX_LEN     = MaxLenDef,
  parameter int BUCKET_BITS = BucketBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        accept,
  input  logic [7:0]  in_byte,
  input  logic        in_end_mark,
  output logic        wr_en,
  output wth_entry_t  wr_data
);

  localparam int               LenW       = $clog2(MAX_LEN);
  localparam logic [LenW-1:0]  Cap        = LenW'(MAX_LEN - 1);
  localparam logic [31:0]      BucketMask = 32'((64'd1 << BUCKET_BITS) - 64'd1);

  logic [31:0]     seed_r;
  logic [LenW-1:0] len_r, len_nxt;
  logic [31:0]     hash_r, hash_nxt;
  logic [31:0]     pfx_r [3];
  logic [7:0]      rec_r [3];
  logic            shift_en;

  logic            closing;
  logic            open_tok;
  logic [31:0]     h0;
  logic [31:0]     tok_hash;
  logic [LenW-1:0] tok_len;

  assign closing  = in_end_mark || is_delim(in_byte);
  assign open_tok = (len_r != '0);
  assign h0       = open_tok ? hash_r : seed_r;

  // cap-trim of a trailing partial UTF-8 character
  always_comb begin
    tok_hash = hash_r;
    tok_len  = len_r;
    if (closing && len_r == Cap && rec_r[0][7]) begin
      if (rec_r[0][7:6] == 2'b11) begin
        tok_hash = pfx_r[0];
        tok_len  = len_r - LenW'(1);
      end else if (rec_r[1][7:5] == 3'b111) begin
        tok_hash = pfx_r[1];
        tok_len  = len_r - LenW'(2);
      end else if (rec_r[2][7:3] == 5'b11110) begin
        tok_hash = pfx_r[2];
        tok_len  = len_r - LenW'(3);
      end
    end
  end

  always_comb begin
    wr_en                = 1'b0;
    wr_data.has_tok      = 1'b0;
    wr_data.tok_bucket   = BucketW'(tok_hash & Mask31 & BucketMask);
    wr_data.tok_len      = TokLenW'(32'(tok_len));
    wr_data.has_punct    = 1'b0;
    wr_data.punct_bucket = BucketW'(mix_byte(seed_r, in_byte) & Mask31 & BucketMask);
    len_nxt              = len_r;
    hash_nxt             = hash_r;
    shift_en             = 1'b0;
    if (accept) begin
      if (closing) begin
        wr_en           = open_tok;
        wr_data.has_tok = open_tok;
        len_nxt         = '0;
      end else if (in_byte == ChCr || len_r == Cap) begin
        // ignored, or dropped past the cap
      end else if (is_punct(in_byte)) begin
        wr_en             = 1'b1;
        wr_data.has_tok   = open_tok;
        wr_data.has_punct = 1'b1;
        len_nxt           = '0;
      end else begin
        shift_en = 1'b1;
        hash_nxt = mix_byte(h0, in_byte);
        len_nxt  = len_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SeedReset;
      len_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end
      len_r <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hash_r <= hash_nxt;
    if (shift_en) begin
      pfx_r[2] <= pfx_r[1];
      pfx_r[1] <= pfx_r[0];
      pfx_r[0] <= h0;
      rec_r[2] <= rec_r[1];
      rec_r[1] <= rec_r[0];
      rec_r[0] <= in_byte;
    end
  end

`ifndef SYNTH
  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n) len_r <= Cap)
    else $error("token length beyond cap");
  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && closing) |=> (len_r == '0))
    else $error("closing request left token open");
`endif

endmodule

/* rtl/wth_fifo.sv */
// ----------------------------------------------------------------------------
// wth_fifo: short entry queue between front and back
// Flop-based, one write and one read per cycle, head visible combinationally.
// ----------------------------------------------------------------------------
module wth_fifo
  import wth_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  wth_entry_t wr_data,
  input  logic       rd_en,
  output wth_entry_t rd_data,
  output logic       full,
  output logic       empty
);

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = PtrW + 1;

  wth_entry_t      mem_r [QueueDepth];
  logic [PtrW-1:0] wp_r, rp_r;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == CntW'(QueueDepth));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    case ({wr_en, rd_en})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) begin
        wp_r <= wp_r + 1'b1;
      end
      if (rd_en) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(wr_en && full))
    else $error("write to full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(rd_en && empty))
    else $error("read from empty queue");
  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || cnt_r == CntW'(QueueDepth)) |-> (wp_r == rp_r))
    else $error("queue pointers disagree with count");
`endif

endmodule

/* rtl/wth_back.sv */
// ----------------------------------------------------------------------------
// wth_back: result sequencer
// Emits the queue head as one or two results, token first, then punctuation.
// ----------------------------------------------------------------------------
module wth_back
  import wth_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  wth_entry_t         head,
  input  logic               q_empty,
  output logic               q_rd_en,
  input  logic               pop,
  output logic               empty,
  output logic [BucketW-1:0] out_bucket,
  output logic [TokLenW-1:0] out_token_length,
  output logic               out_last_result
);

  logic phase_r, phase_nxt;  // token half of a two-result entry already taken
  logic pair;
  logic show_tok;
  logic taken;

  assign pair     = head.has_tok && head.has_punct;
  assign show_tok = head.has_tok && !phase_r;
  assign taken    = pop && !q_empty;
  assign empty    = q_empty;

  assign out_bucket       = show_tok ? head.tok_bucket : head.punct_bucket;
  assign out_token_length = show_tok ? head.tok_len : TokLenW'(1);
  assign out_last_result  = !(show_tok && head.has_punct);

  always_comb begin
    q_rd_en   = 1'b0;
    phase_nxt = phase_r;
    if (taken) begin
      if (pair && !phase_r) begin
        phase_nxt = 1'b1;
      end else begin
        phase_nxt = 1'b0;
        q_rd_en   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

`ifndef SYNTH
  a_phase_pair: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (!q_empty && pair))
    else $error("second half pending without a two-result entry");
`endif

endmodule
